FILE: rtl/core/ias_pkg.sv
// ----------------------------------------------------------------------------
// IAS execute package
// Shared types, opcodes and datapath commands for the IAS execute unit.
// ----------------------------------------------------------------------------
package ias_pkg;

  localparam int WordW = 40;
  localparam int AddrW = 12;
  localparam int OpW   = 8;
  localparam int CntW  = 6;

  localparam logic [OpW-1:0] OP_LOAD     = 8'h01;
  localparam logic [OpW-1:0] OP_LOAD_NEG = 8'h02;
  localparam logic [OpW-1:0] OP_LOAD_ABS = 8'h03;
  localparam logic [OpW-1:0] OP_LOAD_NAB = 8'h04;
  localparam logic [OpW-1:0] OP_ADD      = 8'h05;
  localparam logic [OpW-1:0] OP_SUB      = 8'h06;
  localparam logic [OpW-1:0] OP_ADD_ABS  = 8'h07;
  localparam logic [OpW-1:0] OP_SUB_ABS  = 8'h08;
  localparam logic [OpW-1:0] OP_LOAD_MQM = 8'h09;
  localparam logic [OpW-1:0] OP_LOAD_MQ  = 8'h0A;
  localparam logic [OpW-1:0] OP_MUL      = 8'h0B;
  localparam logic [OpW-1:0] OP_DIV      = 8'h0C;
  localparam logic [OpW-1:0] OP_JMP_L    = 8'h0D;
  localparam logic [OpW-1:0] OP_JMP_R    = 8'h0E;
  localparam logic [OpW-1:0] OP_JPL_L    = 8'h0F;
  localparam logic [OpW-1:0] OP_JPL_R    = 8'h10;
  localparam logic [OpW-1:0] OP_STOR_L   = 8'h12;
  localparam logic [OpW-1:0] OP_STOR_R   = 8'h13;
  localparam logic [OpW-1:0] OP_LSH      = 8'h14;
  localparam logic [OpW-1:0] OP_RSH      = 8'h15;
  localparam logic [OpW-1:0] OP_STOR     = 8'h21;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [AddrW-1:0] address;
    logic [WordW-1:0] operand;
  } ias_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] accumulator;
    logic signed [WordW-1:0] multiplier_quotient;
    logic                    store_enable;
    logic [AddrW-1:0]        store_address;
    logic [WordW-1:0]        store_data;
    logic                    branch_taken;
    logic [AddrW-1:0]        branch_address;
    logic                    branch_right_half;
  } ias_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input item, run the non-serial ops
    logic mul_init;
    logic div_init;
    logic step;    // one serial iteration
    logic finish;  // apply signs and write AC/MQ
    logic emit;    // copy the finished result into the output register
  } ias_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic last;    // the serial count is on its final step
  } ias_sts_t;

  function automatic logic [WordW-1:0] abs40(input logic [WordW-1:0] v);
    return v[WordW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

FILE: rtl/core/ias_ctrl.sv
// ----------------------------------------------------------------------------
// IAS execute controller
// Sequences one item at a time: direct ops or a 40-step serial unit.
// ----------------------------------------------------------------------------
module ias_ctrl import ias_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  ias_sts_t sts,
  output ias_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_INIT, S_RUN, S_DONE} state_t;
  state_t state;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load     = (state == S_IDLE) && in_valid && !in_stall;
    cmd.mul_init = (state == S_INIT) && sts.is_mul;
    cmd.div_init = (state == S_INIT) && sts.is_div;
    cmd.step     = (state == S_RUN);
    cmd.finish   = (state == S_RUN) && sts.last;
    cmd.emit     = (state == S_DONE) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.load) state <= S_INIT;
        end
        S_INIT: begin
          if (sts.is_mul || sts.is_div) state <= S_RUN;
          else state <= S_DONE;
        end
        S_RUN: begin
          if (sts.last) state <= S_DONE;
        end
        S_DONE: begin
          // A finished item waits here while the previous result is stalled.
          if (cmd.emit) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid) else $error("result not shown");
  a_finish_run: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_DONE) else $error("finish lost");

endmodule

FILE: rtl/core/ias_dpath.sv
// ----------------------------------------------------------------------------
// IAS execute datapath
// AC and MQ registers, direct ops and a shared bit-serial mul/div unit.
// ----------------------------------------------------------------------------
module ias_dpath import ias_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  ias_in_t  in_data,
  input  ias_cmd_t cmd,
  output ias_sts_t sts,
  output ias_out_t out_data
);

  logic [WordW-1:0] acc, mq;
  logic [OpW-1:0]   op;
  logic [WordW-1:0] m;
  logic [WordW-1:0] sa, sb;   // magnitudes for the serial unit
  logic [WordW-1:0] hi, lo;   // product halves or remainder/quotient
  logic             neg_q, neg_r;
  logic [CntW-1:0]  cnt;
  logic             st_en, br, brr;
  logic [AddrW-1:0] st_addr, br_addr;
  logic [WordW-1:0] st_data;

  logic [WordW-1:0] m_abs, acc_next, mq_next;
  logic [WordW-1:0] st_data_next;
  logic             st_en_next, br_next, brr_next;
  logic [WordW:0]   mul_sum, div_trial;
  logic [WordW-1:0] div_rem;

  assign m_abs = abs40(in_data.operand);
  assign sts = '{is_mul: (op == OP_MUL),
                 is_div: (op == OP_DIV) && (m != '0),
                 last:   (cnt == CntW'(WordW - 1))};

  // Shift-add multiply step: hi:lo shifts right, sa is added on multiplier bits in lo.
  assign mul_sum   = {1'b0, hi} + (lo[0] ? {1'b0, sa} : '0);
  // Restoring divide step: remainder hi, dividend bits shift out of lo.
  assign div_rem   = {hi[WordW-2:0], lo[WordW-1]};
  assign div_trial = {hi[WordW-1], div_rem} - {1'b0, sb};

  always_comb begin
    acc_next = acc;
    mq_next  = mq;
    st_en_next = 1'b0;
    st_data_next = '0;
    br_next  = 1'b0;
    brr_next = 1'b0;
    unique case (in_data.opcode)
      OP_LOAD:     acc_next = in_data.operand;
      OP_LOAD_NEG: acc_next = ~in_data.operand + 1'b1;
      OP_LOAD_ABS: acc_next = m_abs;
      OP_LOAD_NAB: acc_next = ~m_abs + 1'b1;
      OP_ADD:      acc_next = acc + in_data.operand;
      OP_SUB:      acc_next = acc - in_data.operand;
      OP_ADD_ABS:  acc_next = acc + m_abs;
      OP_SUB_ABS:  acc_next = acc - m_abs;
      OP_LOAD_MQM: mq_next  = in_data.operand;
      OP_LOAD_MQ:  acc_next = mq;
      OP_JMP_L:    br_next = 1'b1;
      OP_JMP_R: begin
        br_next = 1'b1;
        brr_next = 1'b1;
      end
      OP_JPL_L:    br_next = !acc[WordW-1];
      OP_JPL_R: begin
        br_next  = !acc[WordW-1];
        brr_next = !acc[WordW-1];
      end
      OP_STOR_L: begin
        st_en_next = 1'b1;
        st_data_next = in_data.operand;
        st_data_next[20 +: AddrW] = acc[AddrW-1:0];
      end
      OP_STOR_R: begin
        st_en_next = 1'b1;
        st_data_next = in_data.operand;
        st_data_next[AddrW-1:0] = acc[AddrW-1:0];
      end
      OP_LSH:      acc_next = {acc[WordW-2:0], 1'b0};
      OP_RSH:      acc_next = {acc[WordW-1], acc[WordW-1:1]};
      OP_STOR: begin
        st_en_next = 1'b1;
        st_data_next = acc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      mq  <= '0;
    end else if (cmd.load) begin
      acc <= acc_next;
      mq  <= mq_next;
    end else if (cmd.finish) begin
      if (sts.is_mul) begin
        // Last step result is {mul_sum, lo[39:1]} before negation.
        if (neg_q) begin
          {acc, mq} <= ~{mul_sum, lo[WordW-1:1]} + 1'b1;
        end else begin
          {acc, mq} <= {mul_sum, lo[WordW-1:1]};
        end
      end else begin
        logic [WordW-1:0] q_f, r_f;
        q_f = {lo[WordW-2:0], !div_trial[WordW]};
        r_f = div_trial[WordW] ? div_rem : div_trial[WordW-1:0];
        mq  <= neg_q ? (~q_f + 1'b1) : q_f;
        acc <= neg_r ? (~r_f + 1'b1) : r_f;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.mul_init || cmd.div_init) begin
      cnt <= '0;
    end else if (cmd.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op      <= in_data.opcode;
      m       <= in_data.operand;
      st_en   <= st_en_next;
      st_data <= st_data_next;
      st_addr <= in_data.address;
      br      <= br_next;
      br_addr <= br_next ? in_data.address : '0;
      brr     <= brr_next;
    end
    if (cmd.mul_init) begin
      sa    <= abs40(mq);
      hi    <= '0;
      lo    <= abs40(m);
      neg_q <= mq[WordW-1] ^ m[WordW-1];
    end else if (cmd.div_init) begin
      sb    <= abs40(m);
      hi    <= '0;
      lo    <= abs40(acc);
      neg_q <= acc[WordW-1] ^ m[WordW-1];
      neg_r <= acc[WordW-1];
    end else if (cmd.step) begin
      if (sts.is_mul) begin
        hi <= mul_sum[WordW:1];
        lo <= {mul_sum[0], lo[WordW-1:1]};
      end else begin
        hi <= div_trial[WordW] ? div_rem : div_trial[WordW-1:0];
        lo <= {lo[WordW-2:0], !div_trial[WordW]};
      end
    end
  end

  // The output register holds a result item while the next one executes.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.accumulator         <= acc;
      out_data.multiplier_quotient <= mq;
      out_data.store_enable        <= st_en;
      out_data.store_address       <= st_addr;
      out_data.store_data          <= st_data;
      out_data.branch_taken        <= br;
      out_data.branch_address      <= br_addr;
      out_data.branch_right_half   <= brr;
    end
  end

  a_mq_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.load && !cmd.finish |=> $stable(mq)) else $error("MQ changed");
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.load && !cmd.finish |=> $stable(acc)) else $error("AC changed");
  a_finish_serial: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> sts.is_mul || sts.is_div) else $error("bad finish");

endmodule

FILE: rtl/core/ias_instruction_execute_unit.sv
// Each accepted item passes through the INIT and DONE states before its result
// is offered; MUL and DIV with a nonzero divisor also pass through RUN.
// Throughput: one item at a time; the next item is accepted once the result is
// registered and the controller is idle again. MUL and DIV with a nonzero
// divisor run 40 steps on one shared shift-add / restoring-divide unit.
// Reset (rst, synchronous, active high) clears AC, MQ and the controller.
// ----------------------------------------------------------------------------
// IAS instruction execute unit
// Executes one IAS instruction per item and reports AC, MQ, store and jump.
// ----------------------------------------------------------------------------
module ias_instruction_execute_unit import ias_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  ias_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ias_out_t out_data
);

  ias_cmd_t cmd;
  ias_sts_t sts;

  ias_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  ias_dpath u_dpath (
    .clk(clk), .rst(rst), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );

endmodule
